@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers. Both sample on the rising edge of clk.
// ASSERT_SYNC is switched off while rst_n is low; ASSERT_ALWAYS also checks during reset.

`ifndef SYNTH
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/dqs_pkg.sv @@
`timescale 1ns / 1ps

package dqs_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef logic signed [31:0] dqs_word_t;
  typedef logic [CNT_W-1:0]   dqs_cnt_t;
  typedef logic [IDX_W-1:0]   dqs_idx_t;

  // Request codes.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_CONTAINS   = 3'd4;
  localparam logic [2:0] REQ_REMOVE     = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic      push_front;
    logic      push_back;
    logic      pop_front;
    logic      remove;
    dqs_word_t key;
    dqs_cnt_t  count;
  } dqs_ctl_t;

endpackage

@@ hdl/dqs_cell.sv @@
`timescale 1ns / 1ps

module dqs_cell
  import dqs_pkg::*;
(
  input  logic      clk,
  input  dqs_ctl_t  ctl,
  input  dqs_cnt_t  count_nxt,
  input  dqs_idx_t  cell_idx,
  input  dqs_word_t left_value,
  input  dqs_word_t right_value,
  input  logic      seen_in,
  input  dqs_word_t back_in,
  output dqs_word_t value,
  output dqs_word_t value_nxt,
  output logic      seen_out,
  output dqs_word_t back_out
);

  dqs_word_t value_r;
  dqs_cnt_t  idx_ext;
  logic      occupied;
  logic      is_back;

  assign idx_ext  = CNT_W'(cell_idx);
  assign occupied = idx_ext < ctl.count;
  // Seen means a match at this cell or at any cell nearer the front.
  assign seen_out = seen_in | (occupied && (value_r == ctl.key));
  assign is_back  = (idx_ext + CNT_W'(1)) == count_nxt;
  assign back_out = is_back ? value_nxt : back_in;
  assign value    = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.push_front) begin
      value_nxt = left_value;
    end else if (ctl.push_back && (idx_ext == ctl.count)) begin
      value_nxt = ctl.key;
    end else if (ctl.pop_front) begin
      value_nxt = right_value;
    end else if (ctl.remove && seen_out) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ hdl/deque_with_value_search.sv @@
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values with value search.
// Requests arrive on the in_ channel: in_tuser carries the request code and
// in_tdata the value to push, look for or remove. Each accepted transfer
// produces exactly one result transfer on the out_ channel with the status,
// the found flag, the front and back values, the count and the empty flag.
// The values live in a row of cells, front in cell 0. Every cell compares
// its value with the key and passes the match flag and its data to its
// neighbors, so a push, pop, search or removal is worked out combinationally.
// The result is captured in the output register and appears in the cycle
// after the input transfer. Throughput is one request per cycle while the
// receiver takes results; the ripple of the match flag along the cell row
// sets the longest path. When the receiver stalls, the held result stays
// put and no new request is taken until it leaves. Reset empties the queue
// and drops any pending result; the cell contents themselves are not cleared.
`include "assert_macros.svh"

module deque_with_value_search
  import dqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] found, [32:1] front_value, [64:33] back_value, [69:65] item_count,
  // [70] is_empty, [71] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic      in_xfer;
  logic [2:0] req_type;
  dqs_word_t item_value;
  dqs_cnt_t  count_r, count_nxt;
  logic      full, empty, found;
  logic [1:0] status;
  dqs_ctl_t  ctl;

  dqs_word_t cell_value [CAPACITY];
  dqs_word_t cell_nxt   [CAPACITY];
  logic      seen       [CAPACITY+1];
  dqs_word_t back_chain [CAPACITY+1];

  logic       out_valid_r;
  logic [1:0] status_r;
  logic       found_r;
  dqs_word_t  front_r, back_r;
  logic [4:0] count_out_r;
  logic       empty_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign req_type   = in_tuser;
  assign item_value = in_tdata;

  assign full  = count_r == CNT_W'(CAPACITY);
  assign empty = count_r == '0;
  // The end of the match chain tells whether any stored entry matched.
  assign found = ((req_type == REQ_CONTAINS) || (req_type == REQ_REMOVE))
                 && seen[CAPACITY];

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    case (req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) status = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) status = ST_EMPTY;
        else count_nxt = count_r - CNT_W'(1);
      end
      REQ_CONTAINS: begin
        if (empty) status = ST_EMPTY;
      end
      REQ_REMOVE: begin
        if (empty) status = ST_EMPTY;
        else if (seen[CAPACITY]) count_nxt = count_r - CNT_W'(1);
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    ctl.push_front = in_xfer && (req_type == REQ_PUSH_FRONT) && !full;
    ctl.push_back  = in_xfer && (req_type == REQ_PUSH_BACK) && !full;
    ctl.pop_front  = in_xfer && (req_type == REQ_POP_FRONT) && !empty;
    ctl.remove     = in_xfer && (req_type == REQ_REMOVE);
    ctl.key        = item_value;
    ctl.count      = count_r;
  end

  assign seen[0]       = 1'b0;
  assign back_chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dqs_word_t left_v, right_v;
    // The front cell takes the key on a push at the front; the last cell
    // has no right neighbor and its value is dropped on a shift anyway.
    assign left_v  = (g == 0) ? item_value : cell_value[(g == 0) ? 0 : g - 1];
    assign right_v = cell_value[(g == CAPACITY - 1) ? g : g + 1];

    dqs_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count_nxt   (count_nxt),
      .cell_idx    (IDX_W'(g)),
      .left_value  (left_v),
      .right_value (right_v),
      .seen_in     (seen[g]),
      .back_in     (back_chain[g]),
      .value       (cell_value[g]),
      .value_nxt   (cell_nxt[g]),
      .seen_out    (seen[g+1]),
      .back_out    (back_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: the state as it stands after this request.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r    <= status;
      found_r     <= found;
      front_r     <= (count_nxt != '0) ? cell_nxt[0] : '0;
      back_r      <= (count_nxt != '0) ? back_chain[CAPACITY] : '0;
      count_out_r <= 5'(count_nxt);
      empty_r     <= count_nxt == '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, empty_r, count_out_r, back_r, front_r, found_r};

  `ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CNT_W'(CAPACITY)),
                 "entry count above capacity")
  `ASSERT_SYNC(a_push_front_lands,
               (in_xfer && (req_type == REQ_PUSH_FRONT) && !full)
               |=> (cell_value[0] == $past(item_value)),
               "push front did not land in the front cell")
  `ASSERT_SYNC(a_empty_refused,
               (in_xfer && empty && (req_type == REQ_POP_FRONT
                || req_type == REQ_POP_BACK || req_type == REQ_CONTAINS
                || req_type == REQ_REMOVE))
               |=> (status_r == ST_EMPTY && count_r == '0),
               "request on empty queue not refused")
  `ASSERT_SYNC(a_found_ok, (out_tvalid && found_r) |-> (status_r == ST_OK),
               "found flagged with a refusal status")
  `ASSERT_SYNC(a_empty_flag,
               out_tvalid |-> (empty_r == (count_out_r == 5'd0 && count_r == '0)),
               "empty flag disagrees with the count")

endmodule
